// ===== hw/rtl/pds_pkg.sv =====
package pds_pkg;

    localparam int REF_W      = 28;
    localparam int TARGET_W   = 32;
    localparam int DOT_W      = 29;
    localparam int M_W        = 7;
    localparam int PROD_W     = REF_W + M_W;
    localparam int DIVISOR_W  = 7;
    localparam int DIV_CNT_W  = $clog2(PROD_W + 1);

    localparam logic [REF_W-1:0]    REF_RESET  = 28'd96000000;
    localparam logic [PROD_W-1:0]   DOT_MIN    = 35'd20000000;
    localparam logic [PROD_W-1:0]   DOT_MAX    = 35'd400000000;
    localparam logic [PROD_W-1:0]   VCO_MIN    = 35'd1400000000;
    localparam logic [PROD_W-1:0]   VCO_MAX    = 35'd2800000000;
    localparam logic [TARGET_W-1:0] DIFF_LIMIT = 32'hffff_ffff;

    localparam logic [3:0] N_MIN    = 4'd3;
    localparam logic [3:0] N_MAX    = 4'd8;
    localparam logic [4:0] M1_MIN   = 5'd10;
    localparam logic [4:0] M1_MAX   = 5'd20;
    localparam logic [3:0] M2_MIN   = 4'd5;
    localparam logic [3:0] M2_MAX   = 4'd9;
    localparam logic [3:0] P1_MIN   = 4'd1;
    localparam logic [3:0] P1_MAX   = 4'd8;
    localparam logic [3:0] P2_FIXED = 4'd10;
    localparam logic [M_W-1:0] M_MIN = 7'd70;
    localparam logic [M_W-1:0] M_MAX = 7'd120;
    localparam logic [M_W-1:0] P_MIN = 7'd5;
    localparam logic [M_W-1:0] P_MAX = 7'd80;

    // register byte address bit that selects the register index
    localparam int ADDR_W = 3;
    localparam logic REG_REF_CLK = 1'b0;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MCHK,
        S_VDIV_GO,
        S_VDIV_WAIT,
        S_VCHK,
        S_DDIV_GO,
        S_DDIV_WAIT,
        S_EVAL,
        S_STEP_M,
        S_DONE
    } t_state;

    typedef struct packed {
        logic init;
        logic vdiv_start;
        logic vload;
        logic ddiv_start;
        logic step_p;
        logic step_m;
        logic take;
        logic publish;
    } t_dp_cmd;

    typedef struct packed {
        logic m_ok;
        logic div_done;
        logic vco_ok;
        logic dot_ok;
        logic exact;
        logic better;
        logic last_p;
        logic last_combo;
        logic out_free;
    } t_dp_status;

    function automatic logic [DIVISOR_W-1:0] post_div(input logic [3:0] p1);
        return DIVISOR_W'(p1) * DIVISOR_W'(P2_FIXED);
    endfunction

endpackage

// ===== hw/rtl/pds_divider.sv =====
module pds_divider (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [pds_pkg::PROD_W-1:0]    i_dividend,
    input  logic [pds_pkg::DIVISOR_W-1:0] i_divisor,
    output logic                          o_done,
    output logic [pds_pkg::PROD_W-1:0]    o_quotient
);
    import pds_pkg::*;

    logic [DIV_CNT_W-1:0] r_cnt, n_cnt;
    logic [PROD_W-1:0]    r_quo, n_quo;
    logic [DIVISOR_W-1:0] r_rem, n_rem;
    logic [DIVISOR_W-1:0] r_div;
    logic [DIVISOR_W:0]   w_rem_sh;
    logic [DIVISOR_W:0]   w_rem_sub;
    logic                 w_ge;

    // restoring division, one quotient bit per cycle
    always_comb begin
        w_rem_sh  = {r_rem, r_quo[PROD_W-1]};
        w_ge      = (w_rem_sh >= {1'b0, r_div});
        w_rem_sub = w_rem_sh - {1'b0, r_div};
        n_cnt = r_cnt;
        n_quo = r_quo;
        n_rem = r_rem;
        if (i_start) begin
            n_cnt = DIV_CNT_W'(PROD_W);
            n_quo = i_dividend;
            n_rem = '0;
        end else if (r_cnt != '0) begin
            n_cnt = r_cnt - 1'b1;
            n_quo = {r_quo[PROD_W-2:0], w_ge};
            n_rem = w_ge ? w_rem_sub[DIVISOR_W-1:0] : w_rem_sh[DIVISOR_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_quo <= n_quo;
        r_rem <= n_rem;
        if (i_start) begin
            r_div <= i_divisor;
        end
    end

    assign o_done     = (r_cnt == '0);
    assign o_quotient = r_quo;

endmodule

// ===== hw/rtl/pds_datapath.sv =====
module pds_datapath (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  pds_pkg::t_dp_cmd             i_cmd,
    output pds_pkg::t_dp_status          o_status,
    input  logic [pds_pkg::REF_W-1:0]    i_ref_clk,
    input  logic [pds_pkg::TARGET_W-1:0] i_target_hz,
    input  logic                         i_out_stall,
    output logic                         o_out_valid,
    output logic                         o_found,
    output logic [3:0]                   o_div_n,
    output logic [4:0]                   o_div_m1,
    output logic [3:0]                   o_div_m2,
    output logic [3:0]                   o_div_p1,
    output logic [3:0]                   o_div_p2,
    output logic [pds_pkg::DOT_W-1:0]    o_achieved_hz
);
    import pds_pkg::*;

    logic [TARGET_W-1:0]  r_target;
    logic [3:0]           r_n;
    logic [4:0]           r_m1;
    logic [3:0]           r_m2;
    logic [3:0]           r_p1;
    logic [PROD_W-1:0]    r_prod;
    logic [TARGET_W-1:0]  r_vco;
    logic                 r_vco_ok;
    logic [TARGET_W-1:0]  r_best_diff;
    logic [3:0]           r_bn;
    logic [4:0]           r_bm1;
    logic [3:0]           r_bm2;
    logic [3:0]           r_bp1;
    logic [DOT_W-1:0]     r_best_dot;
    logic                 r_have;
    logic                 r_out_valid;

    logic [M_W-1:0]       w_m;
    logic [M_W-1:0]       w_p;
    logic                 w_div_start;
    logic [PROD_W-1:0]    w_dividend;
    logic [DIVISOR_W-1:0] w_divisor;
    logic                 w_div_done;
    logic [PROD_W-1:0]    w_quo;
    logic [TARGET_W-1:0]  w_dot;
    logic [TARGET_W-1:0]  w_diff;

    assign w_m = (M_W'(r_m1) << 2) + M_W'(r_m1) + M_W'(r_m2);
    assign w_p = post_div(r_p1);

    // the shared divider does ref*m/n first, then vco/p for each p1
    assign w_div_start = i_cmd.vdiv_start | i_cmd.ddiv_start;
    assign w_dividend  = i_cmd.vdiv_start ? r_prod : PROD_W'(r_vco);
    assign w_divisor   = i_cmd.vdiv_start ? DIVISOR_W'(r_n) : w_p;

    pds_divider u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_dividend),
        .i_divisor  (w_divisor),
        .o_done     (w_div_done),
        .o_quotient (w_quo)
    );

    assign w_dot  = w_quo[TARGET_W-1:0];
    assign w_diff = w_dot - r_target;

    always_comb begin
        o_status.m_ok       = (r_m1 > 5'(r_m2)) && (w_m >= M_MIN) && (w_m <= M_MAX)
                              && (w_p >= P_MIN) && (w_p <= P_MAX);
        o_status.div_done   = w_div_done;
        o_status.vco_ok     = r_vco_ok;
        o_status.dot_ok     = (w_quo >= DOT_MIN) && (w_quo <= DOT_MAX);
        o_status.exact      = (w_dot == r_target);
        o_status.better     = (w_dot > r_target) && (w_diff < r_best_diff);
        o_status.last_p     = (r_p1 == P1_MIN);
        o_status.last_combo = (r_n == N_MAX) && (r_m1 == M1_MIN) && (r_m2 == M2_MIN);
        o_status.out_free   = !r_out_valid || !i_out_stall;
    end

    always_ff @(posedge i_clk) begin
        r_prod <= PROD_W'(i_ref_clk) * PROD_W'(w_m);
        if (i_cmd.init) begin
            r_target    <= i_target_hz;
            r_n         <= N_MIN;
            r_m1        <= M1_MAX;
            r_m2        <= M2_MAX;
            r_p1        <= P1_MAX;
            r_best_diff <= DIFF_LIMIT;
            r_bn        <= '0;
            r_bm1       <= '0;
            r_bm2       <= '0;
            r_bp1       <= '0;
            r_best_dot  <= '0;
            r_have      <= 1'b0;
        end
        if (i_cmd.vload) begin
            r_vco    <= w_quo[TARGET_W-1:0];
            r_vco_ok <= (w_quo >= VCO_MIN) && (w_quo <= VCO_MAX);
        end
        if (i_cmd.step_p) begin
            r_p1 <= r_p1 - 1'b1;
        end
        if (i_cmd.step_m) begin
            r_p1 <= P1_MAX;
            if (r_m2 == M2_MIN) begin
                r_m2 <= M2_MAX;
                if (r_m1 == M1_MIN) begin
                    r_m1 <= M1_MAX;
                    r_n  <= r_n + 1'b1;
                end else begin
                    r_m1 <= r_m1 - 1'b1;
                end
            end else begin
                r_m2 <= r_m2 - 1'b1;
            end
        end
        if (i_cmd.take) begin
            r_best_diff <= w_diff;
            r_bn        <= r_n;
            r_bm1       <= r_m1;
            r_bm2       <= r_m2;
            r_bp1       <= r_p1;
            r_best_dot  <= w_dot[DOT_W-1:0];
            r_have      <= 1'b1;
        end
        if (i_cmd.publish) begin
            o_found       <= r_have;
            o_div_n       <= r_bn;
            o_div_m1      <= r_bm1;
            o_div_m2      <= r_bm2;
            o_div_p1      <= r_bp1;
            o_div_p2      <= r_have ? P2_FIXED : 4'd0;
            o_achieved_hz <= r_best_dot;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.publish) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

// ===== hw/rtl/pds_ctrl.sv =====
module pds_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  pds_pkg::t_dp_status i_status,
    output pds_pkg::t_dp_cmd    o_cmd,
    output pds_pkg::t_state     o_state
);
    import pds_pkg::*;

    t_state r_state, n_state;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:      if (i_in_valid) n_state = S_MCHK;
            S_MCHK:      n_state = i_status.m_ok ? S_VDIV_GO : S_STEP_M;
            S_VDIV_GO:   n_state = S_VDIV_WAIT;
            S_VDIV_WAIT: if (i_status.div_done) n_state = S_VCHK;
            // vco does not depend on p1, so a bad vco rules out the whole row
            S_VCHK:      n_state = i_status.vco_ok ? S_DDIV_GO : S_STEP_M;
            S_DDIV_GO:   n_state = S_DDIV_WAIT;
            S_DDIV_WAIT: if (i_status.div_done) n_state = S_EVAL;
            S_EVAL: begin
                if (i_status.dot_ok && i_status.exact) begin
                    n_state = S_DONE;
                end else if (i_status.last_p) begin
                    n_state = S_STEP_M;
                end else begin
                    n_state = S_DDIV_GO;
                end
            end
            S_STEP_M:    n_state = i_status.last_combo ? S_DONE : S_MCHK;
            S_DONE:      if (i_status.out_free) n_state = S_IDLE;
            default:     n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_stall = 1'b1;
        unique case (r_state)
            S_IDLE: begin
                o_in_stall = 1'b0;
                o_cmd.init = i_in_valid;
            end
            S_VDIV_GO:   o_cmd.vdiv_start = 1'b1;
            S_VDIV_WAIT: o_cmd.vload = i_status.div_done;
            S_DDIV_GO:   o_cmd.ddiv_start = 1'b1;
            S_EVAL: begin
                o_cmd.take   = i_status.dot_ok && (i_status.exact || i_status.better);
                o_cmd.step_p = !(i_status.dot_ok && i_status.exact) && !i_status.last_p;
            end
            S_STEP_M:    o_cmd.step_m = 1'b1;
            S_DONE:      o_cmd.publish = i_status.out_free;
            default: begin
                o_cmd = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_state = r_state;

endmodule

// ===== hw/rtl/pll_divisor_search.sv =====
// channel   direction  handshake                    word
// in        input      i_in_valid / o_in_stall      i_target_hz
// out       output     o_out_valid / i_out_stall    o_found, o_div_*, o_achieved_hz
// cfg       apb        psel/penable/pwrite/pready   reference_clock_hz at byte 0
//
// one word at a time; a search is paced by the single shared radix-2 divider:
// one vco per n/m1/m2 row that passes the m check, one dot clock per p1 where
// the vco is in range; an exact match ends it early
// the next word is taken as soon as a result is loaded, even if it waits on i_out_stall
// reset is synchronous and active low; reference clock resets to 96 MHz
module pll_divisor_search (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [31:0]                         i_target_hz,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic                                o_found,
    output logic [3:0]                          o_div_n,
    output logic [4:0]                          o_div_m1,
    output logic [3:0]                          o_div_m2,
    output logic [3:0]                          o_div_p1,
    output logic [3:0]                          o_div_p2,
    output logic [28:0]                         o_achieved_hz,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [pds_pkg::ADDR_W-1:0]          paddr,
    input  logic [31:0]                         pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready
);
    import pds_pkg::*;

    logic [REF_W-1:0] r_ref_clk;
    t_dp_cmd          w_cmd;
    t_dp_status       w_status;
    t_state           w_state;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ref_clk <= REF_RESET;
        end else if (psel && penable && pwrite && pready
                     && (paddr[ADDR_W-1] == REG_REF_CLK)) begin
            r_ref_clk <= pwdata[REF_W-1:0];
        end
    end

    assign prdata = (paddr[ADDR_W-1] == REG_REF_CLK) ? 32'(r_ref_clk) : 32'd0;

    pds_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_status   (w_status),
        .o_cmd      (w_cmd),
        .o_state    (w_state)
    );

    pds_datapath u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_status      (w_status),
        .i_ref_clk     (r_ref_clk),
        .i_target_hz   (i_target_hz),
        .i_out_stall   (i_out_stall),
        .o_out_valid   (o_out_valid),
        .o_found       (o_found),
        .o_div_n       (o_div_n),
        .o_div_m1      (o_div_m1),
        .o_div_m2      (o_div_m2),
        .o_div_p1      (o_div_p1),
        .o_div_p2      (o_div_p2),
        .o_achieved_hz (o_achieved_hz)
    );

    // a word taken in starts a search, so the input stalls next cycle
    a_stall_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input not stalled during search");

    // publishing only happens from the done state
    a_publish_in_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.publish |-> (w_state == S_DONE))
        else $error("result loaded outside done state");

    a_not_found_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_found) |-> (o_div_n == 4'd0) && (o_div_m1 == 5'd0)
            && (o_div_p2 == 4'd0) && (o_achieved_hz == 29'd0))
        else $error("not-found result carries nonzero fields");

    a_found_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_found) |-> (o_div_p2 == P2_FIXED)
            && (o_div_m1 > 5'(o_div_m2))
            && (35'(o_achieved_hz) >= DOT_MIN) && (35'(o_achieved_hz) <= DOT_MAX))
        else $error("found result outside divisor or dot clock limits");

endmodule

// ===== bench/pll_divisor_search_checker.sv =====
module pll_divisor_search_checker (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    input  logic                       i_in_stall,
    input  logic [31:0]                i_target_hz,
    input  logic                       i_out_valid,
    input  logic                       i_out_stall,
    input  logic                       i_found,
    input  logic [3:0]                 i_div_n,
    input  logic [4:0]                 i_div_m1,
    input  logic [3:0]                 i_div_m2,
    input  logic [3:0]                 i_div_p1,
    input  logic [3:0]                 i_div_p2,
    input  logic [28:0]                i_achieved_hz,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [pds_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                pwdata,
    input  logic [31:0]                prdata,
    input  logic                       pready,
    output int                         o_fail_count,
    output int                         o_pending,
    output int                         o_checked,
    output int                         o_found_count,
    output int                         o_exact_count
);
    timeunit 1ns;
    timeprecision 1ps;

    import pds_pkg::*;

    localparam logic [ADDR_W-1:0] REF_CLK_ADDR = {REG_REF_CLK, 2'b00};

    typedef struct packed {
        logic        found;
        logic [3:0]  n;
        logic [4:0]  m1;
        logic [3:0]  m2;
        logic [3:0]  p1;
        logic [3:0]  p2;
        logic [28:0] dot_hz;
    } t_divisor_set;

    logic [REF_W-1:0] ref_clk_hz;
    t_divisor_set     pending_sets[$];

    initial begin
        o_fail_count  = 0;
        o_pending     = 0;
        o_checked     = 0;
        o_found_count = 0;
        o_exact_count = 0;
        ref_clk_hz    = REF_RESET;
    end

    // walks the divisor space in search order; first exact hit wins,
    // else the first closest clock strictly above the target
    function automatic t_divisor_set search_divisors(input logic [31:0] target,
                                                     input logic [REF_W-1:0] ref_hz);
        t_divisor_set best;
        logic [63:0]  best_gap;
        logic [63:0]  m;
        logic [63:0]  p;
        logic [63:0]  vco;
        logic [63:0]  dot;
        best     = '0;
        best_gap = 64'(DIFF_LIMIT);
        for (int n = int'(N_MIN); n <= int'(N_MAX); n++)
            for (int m1 = int'(M1_MAX); m1 >= int'(M1_MIN); m1--)
                for (int m2 = int'(M2_MAX); m2 >= int'(M2_MIN); m2--)
                    for (int p1 = int'(P1_MAX); p1 >= int'(P1_MIN); p1--) begin
                        m = 64'(5 * m1 + m2);
                        p = 64'(p1 * int'(P2_FIXED));
                        if (m1 <= m2 || m < 64'(M_MIN) || m > 64'(M_MAX)) continue;
                        if (p < 64'(P_MIN) || p > 64'(P_MAX)) continue;
                        vco = (64'(ref_hz) * m) / 64'(n);
                        dot = vco / p;
                        if (dot < 64'(DOT_MIN) || dot > 64'(DOT_MAX)) continue;
                        if (vco < 64'(VCO_MIN) || vco > 64'(VCO_MAX)) continue;
                        if (dot == 64'(target) ||
                            (dot > 64'(target) && dot - 64'(target) < best_gap)) begin
                            best = '{1'b1, 4'(n), 5'(m1), 4'(m2), 4'(p1), P2_FIXED,
                                     29'(dot)};
                            if (dot == 64'(target)) return best;
                            best_gap = dot - 64'(target);
                        end
                    end
        return best;
    endfunction

    task automatic check_field(input string name, input longint want, input longint got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            o_fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_divisor_set want;
        if (!i_rst_n) begin
            ref_clk_hz = REF_RESET;
        end else begin
            if (psel && penable && pready && paddr == REF_CLK_ADDR) begin
                if (pwrite) begin
                    ref_clk_hz = pwdata[REF_W-1:0];
                end else begin
                    check_field("prdata", longint'({4'b0, ref_clk_hz}), longint'(prdata));
                end
            end
            if (i_in_valid && !i_in_stall) begin
                want = search_divisors(i_target_hz, ref_clk_hz);
                if (want.found && 32'(want.dot_hz) == i_target_hz) o_exact_count++;
                pending_sets.push_back(want);
            end
            if (i_out_valid && !i_out_stall) begin
                o_checked++;
                if (pending_sets.size() == 0) begin
                    $error("result word with no target waiting");
                    o_fail_count++;
                end else begin
                    want = pending_sets.pop_front();
                    if (want.found) o_found_count++;
                    check_field("found", want.found, i_found);
                    check_field("div_n", want.n, i_div_n);
                    check_field("div_m1", want.m1, i_div_m1);
                    check_field("div_m2", want.m2, i_div_m2);
                    check_field("div_p1", want.p1, i_div_p1);
                    check_field("div_p2", want.p2, i_div_p2);
                    check_field("achieved_hz", want.dot_hz, i_achieved_hz);
                end
            end
        end
        o_pending = pending_sets.size();
    end

endmodule

// ===== bench/pll_divisor_search_tb.sv =====
module pll_divisor_search_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import pds_pkg::*;

    localparam logic [ADDR_W-1:0] REF_CLK_ADDR = {REG_REF_CLK, 2'b00};
    // overall cycle limit for the run; reaching it ends the test as NOT OK
    localparam int CYCLE_LIMIT = 48_000_000;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_in_valid;
    logic                o_in_stall;
    logic [31:0]         i_target_hz;
    logic                o_out_valid;
    logic                i_out_stall;
    logic                o_found;
    logic [3:0]          o_div_n;
    logic [4:0]          o_div_m1;
    logic [3:0]          o_div_m2;
    logic [3:0]          o_div_p1;
    logic [3:0]          o_div_p2;
    logic [28:0]         o_achieved_hz;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [ADDR_W-1:0]   paddr;
    logic [31:0]         pwdata;
    logic [31:0]         prdata;
    logic                pready;

    int fail_count;
    int pending;
    int checked;
    int found_count;
    int exact_count;
    int cycles;
    int sent;
    int settings;
    int send_calm;
    int recv_calm;
    logic [REF_W-1:0] ref_now;

    pll_divisor_search dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_target_hz   (i_target_hz),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_found       (o_found),
        .o_div_n       (o_div_n),
        .o_div_m1      (o_div_m1),
        .o_div_m2      (o_div_m2),
        .o_div_p1      (o_div_p1),
        .o_div_p2      (o_div_p2),
        .o_achieved_hz (o_achieved_hz),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    pll_divisor_search_checker checker_i (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .i_in_stall    (o_in_stall),
        .i_target_hz   (i_target_hz),
        .i_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .i_found       (o_found),
        .i_div_n       (o_div_n),
        .i_div_m1      (o_div_m1),
        .i_div_m2      (o_div_m2),
        .i_div_p1      (o_div_p1),
        .i_div_p2      (o_div_p2),
        .i_achieved_hz (o_achieved_hz),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .o_fail_count  (fail_count),
        .o_pending     (pending),
        .o_checked     (checked),
        .o_found_count (found_count),
        .o_exact_count (exact_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("pll_divisor_search_tb NOT OK");
            $finish;
        end
    end

    // receiver: holds each result word for a random number of cycles,
    // with runs of back-to-back acceptance now and then
    initial begin
        int hold;
        i_out_stall = 1'b0;
        recv_calm   = 0;
        forever begin
            @(negedge i_clk);
            if (o_out_valid === 1'b1) begin
                if (recv_calm > 0) begin
                    recv_calm--;
                    hold = 0;
                end else begin
                    if ($urandom_range(0, 7) == 0) recv_calm = $urandom_range(3, 8);
                    hold = $urandom_range(0, 18);
                end
                if (hold > 0) begin
                    i_out_stall <= 1'b1;
                    repeat (hold) @(negedge i_clk);
                    i_out_stall <= 1'b0;
                end
                @(posedge i_clk);
            end
        end
    end

    // a clock that some divisor set really produces under the given reference, else a random one in the dot range
    function automatic logic [31:0] reachable_hz(input logic [REF_W-1:0] ref_hz);
        int          n;
        int          m1;
        int          m2;
        int          p1;
        logic [63:0] m;
        logic [63:0] vco;
        logic [63:0] dot;
        for (int k = 0; k < 200; k++) begin
            n   = $urandom_range(int'(N_MIN), int'(N_MAX));
            m1  = $urandom_range(int'(M1_MIN), int'(M1_MAX));
            m2  = $urandom_range(int'(M2_MIN), int'(M2_MAX));
            p1  = $urandom_range(int'(P1_MIN), int'(P1_MAX));
            m   = 64'(5 * m1 + m2);
            vco = (64'(ref_hz) * m) / 64'(n);
            dot = vco / 64'(p1 * int'(P2_FIXED));
            if (m1 > m2 && m >= 64'(M_MIN) && m <= 64'(M_MAX) &&
                vco >= 64'(VCO_MIN) && vco <= 64'(VCO_MAX) &&
                dot >= 64'(DOT_MIN) && dot <= 64'(DOT_MAX))
                return dot[31:0];
        end
        return $urandom_range(20_000_000, 400_000_000);
    endfunction

    // entered at a falling edge; valid stays high on return so a zero gap
    // never lowers and raises it in the same step
    task automatic send_target(input logic [31:0] target);
        int gap;
        if (send_calm > 0) begin
            send_calm--;
            gap = 0;
        end else begin
            if ($urandom_range(0, 7) == 0) send_calm = $urandom_range(3, 8);
            gap = $urandom_range(0, 18);
        end
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_target_hz <= target;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        sent++;
        @(negedge i_clk);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        @(negedge i_clk);
        while (pending != 0) @(negedge i_clk);
    endtask

    task automatic apb_access(input logic write, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= write;
        paddr   <= REF_CLK_ADDR;
        pwdata  <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_ref_clock(input logic [31:0] value);
        apb_access(1'b1, value);
        apb_access(1'b0, '0);
        ref_now = value[REF_W-1:0];
        settings++;
    endtask

    task automatic random_targets(input int count);
        int          pick;
        logic [31:0] hit;
        for (int k = 0; k < count; k++) begin
            pick = $urandom_range(0, 99);
            hit  = reachable_hz(ref_now);
            if (pick < 40)
                send_target(hit);
            else if (pick < 55)
                send_target(hit - $urandom_range(1, 5000));
            else if (pick < 65)
                send_target(hit + $urandom_range(1, 5000));
            else if (pick < 85)
                send_target($urandom_range(0, 450_000_000));
            else
                send_target($urandom);
        end
    endtask

    initial begin
        logic [31:0] hit;
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_target_hz = '0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        cycles      = 0;
        sent        = 0;
        settings    = 1;
        send_calm   = 0;
        ref_now     = REF_RESET;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset reference clock: range edges, common pixel clocks, exact hits
        apb_access(1'b0, '0);
        hit = reachable_hz(ref_now);
        send_target(32'd0);
        send_target(32'd1);
        send_target(32'hffff_ffff);
        send_target(32'h8000_0000);
        send_target(32'd19_999_999);
        send_target(32'd20_000_000);
        send_target(32'd400_000_000);
        send_target(32'd400_000_001);
        send_target(32'd25_175_000);
        send_target(32'd148_500_000);
        send_target(hit);
        send_target(hit - 1);
        random_targets(10);
        drain();

        set_ref_clock(32'h0fff_ffff);
        send_target(32'd0);
        send_target(32'd400_000_000);
        send_target(32'hffff_ffff);
        send_target(reachable_hz(ref_now));
        random_targets(20);
        drain();

        // tiny reference: nothing reaches the vco range
        set_ref_clock(32'd1);
        send_target(32'd0);
        send_target(32'd20_000_000);
        drain();

        // upper bits dropped, leaving a zero reference clock
        set_ref_clock(32'hf000_0000);
        send_target(32'd0);
        send_target(32'd25_175_000);
        drain();

        set_ref_clock(32'd27_000_000);
        random_targets(20);
        drain();

        set_ref_clock($urandom_range(20_000_000, 268_435_455));
        random_targets(25);
        drain();

        set_ref_clock(32'(REF_RESET));
        random_targets(5);
        drain();

        repeat (100) @(negedge i_clk);
        $display("%0d targets sent across %0d reference clock settings, %0d results checked",
                 sent, settings, checked);
        $display("%0d results carried a divisor set, %0d of them an exact match",
                 found_count, exact_count);
        if (fail_count == 0)
            $display("pll_divisor_search_tb OK");
        else
            $display("pll_divisor_search_tb NOT OK");
        $finish;
    end

endmodule
